>>> rtl/core/chained_range_remap_min_core_defines.svh
// Assertion macros for the chained range remap core checker.
// Depends on a clk_i / rst_ni pair in the scope that uses them.
`ifndef CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH

// same-cycle implication
`define CRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/crm_pkg.sv
// Shared types and constants of the chained range remap core.
// No dependencies.
package crm_pkg;

  localparam int unsigned CRM_STAGES  = 7;
  localparam int unsigned CRM_ENTRIES = 8;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ActW   = 2;
  localparam int unsigned StageW = 3;
  localparam int unsigned EntryW = 3;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_XLATE   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef struct packed {
    action_e                action;
    logic [StageW-1:0]      stage_idx;
    logic [EntryW-1:0]      entry_idx;
    logic [DataW-1:0]       dest_start;
    logic [DataW-1:0]       source_start;
    logic [DataW-1:0]       span;
    logic [DataW-1:0]       value;
  } crm_item_t;

endpackage

>>> rtl/core/crm_cell.sv
// One remap stage of the chain: holds its range entries and one item register.
// Depends on crm_pkg.
module crm_cell import crm_pkg::*; #(
  parameter int unsigned Entries = CRM_ENTRIES,
  parameter int unsigned CellIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  crm_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output crm_item_t out_item_o
);

  localparam int unsigned EntW = (Entries > 1) ? $clog2(Entries) : 1;

  logic                valid_q;
  crm_item_t           item_q, item_d;
  logic [Entries-1:0]  ent_valid_q;
  logic [DataW-1:0]    src_q   [Entries];
  logic [DataW-1:0]    span_q  [Entries];
  logic [DataW-1:0]    delta_q [Entries];
  logic                take, wr_en, found;
  logic [EntW-1:0]     wr_idx;
  logic [Entries-1:0]  hit;
  logic [DataW-1:0]    mapped;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign wr_idx      = EntW'(in_item_i.entry_idx);
  assign wr_en       = take && (in_item_i.action == ACT_LOAD)
                       && (32'(in_item_i.stage_idx) == 32'(CellIdx))
                       && (32'(in_item_i.entry_idx) < 32'(Entries));
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // all entries compare at once; the lowest hit wins
  always_comb begin
    for (int e = 0; e < Entries; e++) begin
      hit[e] = ent_valid_q[e] && ((in_item_i.value - src_q[e]) < span_q[e]);
    end
    found  = 1'b0;
    mapped = in_item_i.value;
    for (int e = 0; e < Entries; e++) begin
      if (!found && hit[e]) begin
        found  = 1'b1;
        mapped = in_item_i.value + delta_q[e];
      end
    end
    item_d = in_item_i;
    if (in_item_i.action == ACT_XLATE) begin
      item_d.value = mapped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      ent_valid_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (wr_en) begin
        ent_valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
    if (wr_en) begin
      src_q[wr_idx]   <= in_item_i.source_start;
      span_q[wr_idx]  <= in_item_i.span;
      // dest + (value - src) == value + (dest - src) mod 2^32
      delta_q[wr_idx] <= in_item_i.dest_start - in_item_i.source_start;
    end
  end

endmodule

>>> rtl/core/crm_min.sv
// Result stage: running minimum and the output register of the core.
// Depends on crm_pkg.
module crm_min import crm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  crm_item_t        in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] location_o,
  output logic [DataW-1:0] lowest_o
);

  logic             valid_q;
  logic [DataW-1:0] loc_q;
  logic [DataW-1:0] min_q;
  logic             take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign location_o  = loc_q;
  assign lowest_o    = min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      min_q   <= '1;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (take) begin
        if (in_item_i.action == ACT_XLATE) begin
          if (in_item_i.value < min_q) begin
            min_q <= in_item_i.value;
          end
        end else if (in_item_i.action == ACT_RESTART) begin
          min_q <= '1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      loc_q <= (in_item_i.action == ACT_XLATE) ? in_item_i.value : '0;
    end
  end

endmodule

>>> rtl/core/chained_range_remap_min_core.sv
// Each cell, one per stage, registers the item; the crm_min result register follows.
// Throughput: one transaction per cycle unless stalled; loads, translates and restarts
// flow down one cell chain, so a load takes effect in each cell before every later item.
// A stalled output backs up the chain one register at a time.
// Reset: clears every entry valid bit, the item valid bits and sets the minimum to all ones.
// Top level of the chained range remap core; depends on crm_pkg, crm_cell, crm_min.
module chained_range_remap_min_core import crm_pkg::*; #(
  parameter int unsigned Stages  = CRM_STAGES,
  parameter int unsigned Entries = CRM_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stage_index[2:0], entry_index[5:3], dest_start[37:6], source_start[69:38],
  // span[101:70], seed_value[133:102], zero pad[135:134]
  input  logic [135:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // location[31:0], lowest_location[63:32]
  output logic [63:0]  m_axis_tdata
);

  logic      valid [Stages+1];
  logic      ready [Stages+1];
  crm_item_t item  [Stages+1];

  logic [DataW-1:0] location, lowest;

  assign valid[0]               = s_axis_tvalid;
  assign s_axis_tready          = ready[0];
  assign item[0].action         = action_e'(s_axis_tuser);
  assign item[0].stage_idx      = s_axis_tdata[2:0];
  assign item[0].entry_idx      = s_axis_tdata[5:3];
  assign item[0].dest_start     = s_axis_tdata[37:6];
  assign item[0].source_start   = s_axis_tdata[69:38];
  assign item[0].span           = s_axis_tdata[101:70];
  assign item[0].value          = s_axis_tdata[133:102];

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    crm_cell #(
      .Entries(Entries),
      .CellIdx(g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i (valid[g]),
      .in_ready_o (ready[g]),
      .in_item_i  (item[g]),
      .out_valid_o(valid[g+1]),
      .out_ready_i(ready[g+1]),
      .out_item_o (item[g+1])
    );
  end

  crm_min u_min (
    .clk_i,
    .rst_ni,
    .in_valid_i (valid[Stages]),
    .in_ready_o (ready[Stages]),
    .in_item_i  (item[Stages]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .location_o (location),
    .lowest_o   (lowest)
  );

  assign m_axis_tdata = {lowest, location};

endmodule

>>> rtl/core/crm_checker.sv
// Port-level checks for the chained range remap core, bound to its top level.
// Depends on chained_range_remap_min_core_defines.svh.
`include "chained_range_remap_min_core_defines.svh"

module crm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // stalled result holds
  `CRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // input side only backs up behind a stalled output
  `CRM_ASSERT_NOW(a_stall_cause, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // a translated location never lies below the running minimum
  `CRM_ASSERT_NOW(a_min_bound, m_axis_tvalid,
    (m_axis_tdata[63:32] <= m_axis_tdata[31:0]) || (m_axis_tdata[31:0] == 32'd0),
    "running minimum above translated location")

endmodule

bind chained_range_remap_min_core crm_checker u_crm_checker (.*);
